/* rtl/caqt_pkg.sv */
// Package for the connection admission quarantine table.
// Holds the request and result word types and the status codes.
package caqt_pkg;

    typedef struct packed {
        logic        opcode;
        logic [1:0]  family;
        logic [7:0]  addr_len;
        logic [63:0] addr_high;
        logic [63:0] addr_low;
        logic [15:0] port_number;
    } t_req;

    typedef struct packed {
        logic       allowed;
        logic [3:0] status;
    } t_rsp;

    localparam logic [3:0] ST_INVALID     = 4'd0;
    localparam logic [3:0] ST_VERIFIED    = 4'd1;
    localparam logic [3:0] ST_QUARANTINED = 4'd2;
    localparam logic [3:0] ST_NEW_QUAR    = 4'd3;
    localparam logic [3:0] ST_QUAR_FULL   = 4'd4;
    localparam logic [3:0] ST_VFY_INVALID = 4'd5;
    localparam logic [3:0] ST_NOT_QUAR    = 4'd6;
    localparam logic [3:0] ST_MOVED       = 4'd7;
    localparam logic [3:0] ST_VFY_FULL    = 4'd8;

    localparam logic OP_CHECK  = 1'b0;
    localparam logic OP_VERIFY = 1'b1;

    // Entry record: family bit, port, address halves.
    typedef struct packed {
        logic        fam;
        logic [15:0] port;
        logic [63:0] hi;
        logic [63:0] lo;
    } t_entry;

endpackage

/* rtl/connection_admission_quarantine_table.sv */
// An accepted request word goes through the verified scan, the quarantine scan and the
// decide state to a valid result word. Each table is scanned one entry per cycle
// through its memory read port, verified table first, then quarantine; one request
// is processed at a time. A new request word is accepted only in the idle state,
// after the result word of the last request has been taken.
// Reset (synchronous, active low) empties both tables by clearing valid bits.
module connection_admission_quarantine_table
    import caqt_pkg::*;
#(
    parameter int VERIFIED_DEPTH   = 64,
    parameter int QUARANTINE_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);
    localparam int VAW = (VERIFIED_DEPTH > 1) ? $clog2(VERIFIED_DEPTH) : 1;
    localparam int QAW = (QUARANTINE_DEPTH > 1) ? $clog2(QUARANTINE_DEPTH) : 1;
    localparam int VCW = $clog2(VERIFIED_DEPTH + 1);
    localparam int QCW = $clog2(QUARANTINE_DEPTH + 1);

    typedef enum logic [2:0] {S_IDLE, S_VSCAN, S_QSCAN, S_DECIDE, S_OUT} t_state;

    t_state         r_state;
    t_entry         r_key;
    logic           r_op;
    logic           r_len_ok;
    // Read address counters; they lead the compare stage by one address.
    logic [VCW-1:0] r_vcnt;
    logic [QCW-1:0] r_qcnt;
    logic           r_vcmp, r_qcmp;
    logic [VAW-1:0] r_vidx;
    logic [QAW-1:0] r_qidx;
    logic           r_v_hit, r_v_free_f, r_q_host, r_q_exact, r_q_free_f;
    logic [VAW-1:0] r_v_free;
    logic [QAW-1:0] r_q_free, r_q_exact_idx;
    t_rsp           r_rsp;

    t_entry         v_rd, q_rd;
    logic           v_rd_vld, q_rd_vld;
    logic           v_we, q_we, q_clr;
    logic [VAW-1:0] v_wa;
    logic [QAW-1:0] q_wa;
    logic           len_ok_c;
    t_entry         key_c;
    logic           v_match, q_host_m, q_exact_m;

    caqt_table #(.DEPTH(VERIFIED_DEPTH), .AW(VAW)) u_vtab (
        .i_clk, .i_rst_n,
        .i_rd_addr (r_vcnt[VAW-1:0]), .o_rd_data (v_rd), .o_rd_valid (v_rd_vld),
        .i_wr_en (v_we), .i_wr_addr (v_wa), .i_wr_data (r_key),
        .i_clr_en (1'b0), .i_clr_addr ('0)
    );
    caqt_table #(.DEPTH(QUARANTINE_DEPTH), .AW(QAW)) u_qtab (
        .i_clk, .i_rst_n,
        .i_rd_addr (r_qcnt[QAW-1:0]), .o_rd_data (q_rd), .o_rd_valid (q_rd_vld),
        .i_wr_en (q_we), .i_wr_addr (q_wa), .i_wr_data (r_key),
        .i_clr_en (q_clr), .i_clr_addr (r_q_exact_idx)
    );

    // Length rule and IPv4 normalising of the incoming word.
    always_comb begin
        len_ok_c = (i_req.addr_len > 8'd2) && (i_req.addr_len <= 8'd128);
        case (i_req.family)
            2'd0:    len_ok_c = len_ok_c && (i_req.addr_len >= 8'd16);
            2'd1:    len_ok_c = len_ok_c && (i_req.addr_len >= 8'd28);
            default: len_ok_c = 1'b0;
        endcase
        key_c.fam  = i_req.family[0];
        key_c.port = i_req.port_number;
        key_c.hi   = i_req.family[0] ? i_req.addr_high : 64'd0;
        key_c.lo   = i_req.family[0] ? i_req.addr_low : {32'd0, i_req.addr_low[31:0]};
    end

    assign v_match   = v_rd_vld && (v_rd == r_key);
    assign q_host_m  = q_rd_vld && (q_rd.hi == r_key.hi) && (q_rd.lo == r_key.lo)
                       && (q_rd.fam == r_key.fam);
    assign q_exact_m = q_host_m && (q_rd.port == r_key.port);

    // Table updates happen only in the decide cycle, after both scans.
    always_comb begin
        v_we  = 1'b0;
        q_we  = 1'b0;
        q_clr = 1'b0;
        v_wa  = r_v_free;
        q_wa  = r_q_free;
        if (r_state == S_DECIDE && r_len_ok) begin
            if (r_op == OP_CHECK) begin
                q_we = !r_v_hit && !r_q_host && r_q_free_f;
            end else if (r_q_exact && r_v_free_f) begin
                v_we  = 1'b1;
                q_clr = 1'b1;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcnt  <= '0;
            r_qcnt  <= '0;
            r_vcmp  <= 1'b0;
            r_qcmp  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_key      <= key_c;
                        r_op       <= i_req.opcode;
                        r_len_ok   <= len_ok_c;
                        r_vcnt     <= '0;
                        r_qcnt     <= '0;
                        r_v_hit    <= 1'b0;
                        r_v_free_f <= 1'b0;
                        r_q_host   <= 1'b0;
                        r_q_exact  <= 1'b0;
                        r_q_free_f <= 1'b0;
                        r_v_free   <= '0;
                        r_q_free   <= '0;
                        r_q_exact_idx <= '0;
                        r_state    <= S_VSCAN;
                    end
                end
                S_VSCAN: begin
                    if (r_vcnt < VCW'(VERIFIED_DEPTH)) begin
                        r_vcmp <= 1'b1;
                        r_vidx <= r_vcnt[VAW-1:0];
                        r_vcnt <= r_vcnt + 1'b1;
                    end else begin
                        // Stay in the scan until the compare flag has dropped, so that the last entry is compared.
                        r_vcmp <= 1'b0;
                        if (!r_vcmp) r_state <= S_QSCAN;
                    end
                end
                S_QSCAN: begin
                    if (r_qcnt < QCW'(QUARANTINE_DEPTH)) begin
                        r_qcmp <= 1'b1;
                        r_qidx <= r_qcnt[QAW-1:0];
                        r_qcnt <= r_qcnt + 1'b1;
                    end else begin
                        r_qcmp <= 1'b0;
                        if (!r_qcmp) r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_op == OP_CHECK) begin
                        if (!r_len_ok) begin
                            r_rsp.allowed <= 1'b0;
                            r_rsp.status  <= ST_INVALID;
                        end else if (r_v_hit) begin
                            r_rsp.allowed <= 1'b1;
                            r_rsp.status  <= ST_VERIFIED;
                        end else if (r_q_host) begin
                            r_rsp.allowed <= 1'b0;
                            r_rsp.status  <= ST_QUARANTINED;
                        end else if (!r_q_free_f) begin
                            r_rsp.allowed <= 1'b0;
                            r_rsp.status  <= ST_QUAR_FULL;
                        end else begin
                            r_rsp.allowed <= 1'b1;
                            r_rsp.status  <= ST_NEW_QUAR;
                        end
                    end else begin
                        r_rsp.allowed <= 1'b0;
                        if (!r_len_ok)        r_rsp.status <= ST_VFY_INVALID;
                        else if (!r_q_exact)  r_rsp.status <= ST_NOT_QUAR;
                        else if (!r_v_free_f) r_rsp.status <= ST_VFY_FULL;
                        else                  r_rsp.status <= ST_MOVED;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // Compare stage: memory data for the previous address is valid now.
            if (r_vcmp) begin
                if (v_match) r_v_hit <= 1'b1;
                if (!v_rd_vld && !r_v_free_f) begin
                    r_v_free_f <= 1'b1;
                    r_v_free   <= r_vidx;
                end
            end
            if (r_qcmp) begin
                if (q_host_m) r_q_host <= 1'b1;
                if (q_exact_m && !r_q_exact) begin
                    r_q_exact     <= 1'b1;
                    r_q_exact_idx <= r_qidx;
                end
                if (!q_rd_vld && !r_q_free_f) begin
                    r_q_free_f <= 1'b1;
                    r_q_free   <= r_qidx;
                end
            end
        end
    end

`ifndef SYNTH
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(v_we && q_we)) else $error("both tables written at once");
    a_move_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_we |-> q_clr) else $error("verified insert without quarantine removal");
    a_out_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DECIDE)) else $error("result out of order");
    a_exact_implies_host: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_exact |-> r_q_host) else $error("exact match without host match");
`endif
endmodule

/* rtl/caqt_table.sv */
// One address table: synchronous entry memory with a registered read port,
// plus a valid bit per entry. Depends on caqt_pkg.
module caqt_table
    import caqt_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [AW-1:0] i_rd_addr,
    output t_entry        o_rd_data,
    output logic          o_rd_valid,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  t_entry        i_wr_data,
    input  logic          i_clr_en,
    input  logic [AW-1:0] i_clr_addr
);
    t_entry           mem [DEPTH];
    logic [DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            o_rd_valid <= 1'b0;
        end else begin
            o_rd_valid <= r_valid[i_rd_addr];
            if (i_clr_en) r_valid[i_clr_addr] <= 1'b0;
            if (i_wr_en)  r_valid[i_wr_addr]  <= 1'b1;
        end
    end
endmodule
